// ===== design/boolean_arithmetic_mask_conversion_macros.svh =====
// Assertion macros for the Boolean/arithmetic mask converter.
`ifndef BOOLEAN_ARITHMETIC_MASK_CONVERSION_MACROS_SVH
`define BOOLEAN_ARITHMETIC_MASK_CONVERSION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BAMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bamc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BAMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bamc next-cycle check failed");

`endif

// ===== design/bamc_pkg.sv =====
// Shared constants for the Boolean/arithmetic mask converter.
package bamc_pkg;

	localparam int DATA_WIDTH_DEF   = 32;
	localparam int OUT_WIDTH        = 32;
	localparam int RNG_WIDTH        = 32;
	localparam int ROUNDS_PER_STAGE = 4;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [RNG_WIDTH-1:0] RNG_SEED_FIRST  = 32'd123456789;
	localparam logic [RNG_WIDTH-1:0] RNG_SEED_SECOND = 32'd362436069;
	localparam logic [RNG_WIDTH-1:0] RNG_SEED_THIRD  = 32'd521288629;

	localparam logic KIND_B2A = 1'b0;
	localparam logic KIND_A2B = 1'b1;

endpackage

// ===== design/boolean_arithmetic_mask_conversion.sv =====
// Boolean/arithmetic first-order mask converter. Each beat carries one share and its
// mask: kind 0 turns x xor mask into x minus mask, kind 1 turns x minus mask into
// x xor mask, modulo 2^DATA_WIDTH. A 96-bit xorshift generator advances once per
// accepted beat and supplies the random word that hides intermediate values. The
// block takes one beat per cycle and keeps that rate while results are taken every
// cycle. Each accepted beat passes through the two-entry queue between the front
// end and the carry-round pipeline, then through the pipeline stages, each running
// up to four rounds of the masked carry recurrence. No clearing pass follows reset.
module boolean_arithmetic_mask_conversion #(
	parameter int DATA_WIDTH = bamc_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] masked_value,
	input  logic [31:0] mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] converted
);

`include "boolean_arithmetic_mask_conversion_macros.svh"

	localparam int PW   = 1 + 5 * DATA_WIDTH;
	localparam int RPS  = bamc_pkg::ROUNDS_PER_STAGE;
	localparam int NSTG = (DATA_WIDTH - 1 + RPS - 1) / RPS;
	localparam int CAP  = bamc_pkg::QUEUE_DEPTH + NSTG;
	localparam int OW   = $clog2(CAP + 1);

	logic          push_valid;
	logic          push_ready;
	logic [PW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [PW-1:0] pop_data;
	logic          in_acc;
	logic          out_acc;
	logic [OW-1:0] occ_q;

	bamc_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.PW         (PW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.masked_value (masked_value),
		.mask         (mask),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	bamc_fifo #(
		.WIDTH (PW),
		.DEPTH (bamc_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bamc_back #(
		.DATA_WIDTH (DATA_WIDTH),
		.PW         (PW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.converted (converted)
	);

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track beats held anywhere between input and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   occ_q <= occ_q + OW'(1);
				2'b01:   occ_q <= occ_q - OW'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	`BAMC_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OW'(CAP))
	`BAMC_ASSERT_NOW(a_out_has_beat, out_valid, occ_q != '0)
	`BAMC_ASSERT_NEXT(a_empty_stays_quiet, (occ_q == '0) && !in_acc, !out_valid)

endmodule

// ===== design/bamc_fifo.sv =====
// Short valid/ready queue between the front and the back of the converter.
module bamc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bamc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/bamc_front.sv =====
// Front end: input beat acceptance, xorshift generator and per-kind setup.
module bamc_front #(
	parameter int DATA_WIDTH = bamc_pkg::DATA_WIDTH_DEF,
	parameter int PW         = 1 + 5 * DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  logic [31:0]   masked_value,
	input  logic [31:0]   mask,
	output logic          push_valid,
	input  logic          push_ready,
	output logic [PW-1:0] push_data
);

	localparam int DW = DATA_WIDTH;
	localparam int RW = bamc_pkg::RNG_WIDTH;

	typedef struct packed {
		logic          kind;
		logic [DW-1:0] t;
		logic [DW-1:0] a;
		logic [DW-1:0] m;
		logic [DW-1:0] om;
		logic [DW-1:0] xb;
	} item_t;

	logic [RW-1:0] rng_first_q;
	logic [RW-1:0] rng_second_q;
	logic [RW-1:0] rng_third_q;
	logic [RW-1:0] mix0;
	logic [RW-1:0] mix1;
	logic [RW-1:0] mix2;
	logic [RW-1:0] rng_new;
	logic          accept;
	item_t         item;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// Next generator word; it is the random word for this beat.
	always_comb begin
		mix0    = rng_first_q ^ (rng_first_q << 16);
		mix1    = mix0 ^ (mix0 >> 5);
		mix2    = mix1 ^ (mix1 << 1);
		rng_new = mix2 ^ rng_second_q ^ rng_third_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_first_q  <= bamc_pkg::RNG_SEED_FIRST;
			rng_second_q <= bamc_pkg::RNG_SEED_SECOND;
			rng_third_q  <= bamc_pkg::RNG_SEED_THIRD;
		end else if (accept) begin
			rng_first_q  <= rng_second_q;
			rng_second_q <= rng_third_q;
			rng_third_q  <= rng_new;
		end
	end

	always_comb begin
		logic [DW-1:0] g;
		logic [DW-1:0] v;
		logic [DW-1:0] m;
		logic [DW-1:0] t0;
		logic [DW-1:0] u;
		logic [DW-1:0] r;
		logic [DW-1:0] t1;
		logic [DW-1:0] xb;
		logic [DW-1:0] s;
		g  = DW'(rng_new);
		v  = DW'(masked_value);
		m  = DW'(mask);
		// Boolean to arithmetic: two masked subtract-and-xor passes.
		t0 = ((v ^ g) - g) ^ v;
		u  = g ^ m;
		r  = ((v ^ u) - u) ^ t0;
		// Arithmetic to Boolean: seed the masked carry recurrence.
		t1 = g << 1;
		xb = t1 ^ v;
		s  = (g ^ xb) & m;
		item.kind = kind;
		item.t    = t1;
		item.a    = v;
		item.m    = m;
		item.om   = (g & (g ^ m)) ^ s ^ (t1 & v);
		item.xb   = (kind == bamc_pkg::KIND_B2A) ? r : xb;
	end

	assign push_data = item;

endmodule

// ===== design/bamc_back.sv =====
// Back end: pipelined masked carry rounds and the output register.
module bamc_back #(
	parameter int DATA_WIDTH = bamc_pkg::DATA_WIDTH_DEF,
	parameter int PW         = 1 + 5 * DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [PW-1:0] pop_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   converted
);

	localparam int DW     = DATA_WIDTH;
	localparam int ROUNDS = DATA_WIDTH - 1;
	localparam int RPS    = bamc_pkg::ROUNDS_PER_STAGE;
	localparam int NSTG   = (ROUNDS + RPS - 1) / RPS;

	typedef struct packed {
		logic          kind;
		logic [DW-1:0] t;
		logic [DW-1:0] a;
		logic [DW-1:0] m;
		logic [DW-1:0] om;
		logic [DW-1:0] xb;
	} item_t;

	item_t           st_q   [NSTG];
	item_t           src    [NSTG];
	item_t           nxt    [NSTG];
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] src_vld;
	logic [NSTG:0]   rdy;
	item_t           last;

	// Run up to RPS carry rounds, stopping once all rounds are done.
	function automatic item_t do_rounds(input item_t x, input int base);
		item_t         y;
		logic [DW-1:0] s;
		y = x;
		for (int j = 0; j < RPS; j++) begin
			if (base + j < ROUNDS) begin
				s   = (y.t & y.m) ^ y.om ^ (y.t & y.a);
				y.t = s << 1;
			end
		end
		return y;
	endfunction

	assign rdy[NSTG] = out_ready;
	assign pop_ready = rdy[0];

	for (genvar i = 0; i < NSTG; i++) begin : g_stage
		if (i == 0) begin : g_head
			assign src[i]     = item_t'(pop_data);
			assign src_vld[i] = pop_valid;
		end else begin : g_body
			assign src[i]     = st_q[i-1];
			assign src_vld[i] = vld_q[i-1];
		end

		assign rdy[i] = !vld_q[i] || rdy[i+1];

		always_comb begin
			nxt[i] = do_rounds(src[i], i * RPS);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_q[i] <= src_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && src_vld[i]) begin
				st_q[i] <= nxt[i];
			end
		end
	end

	assign last      = st_q[NSTG-1];
	assign out_valid = vld_q[NSTG-1];
	assign converted = bamc_pkg::OUT_WIDTH'(
		(last.kind == bamc_pkg::KIND_A2B) ? (last.xb ^ last.t) : last.xb);

endmodule

// ===== verif/boolean_arithmetic_mask_conversion_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Boolean/arithmetic mask converter.
module boolean_arithmetic_mask_conversion_test;

	typedef logic [31:0] word_t;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = 24;
	localparam int HOLD_CYCLES      = 300;
	localparam int RANDOM_PER_PHASE = 400;
	localparam int PRESSURE_BEATS   = 60;

	class conversion_scoreboard;
		word_t rng_first;
		word_t rng_second;
		word_t rng_third;
		word_t pending_converted[$];
		int failures;
		int b2a_beats;
		int a2b_beats;
		int checked;

		function new();
			rng_first = bamc_pkg::RNG_SEED_FIRST;
			rng_second = bamc_pkg::RNG_SEED_SECOND;
			rng_third = bamc_pkg::RNG_SEED_THIRD;
			failures = 0;
			b2a_beats = 0;
			a2b_beats = 0;
			checked = 0;
		endfunction

		// Step the xorshift generator; the new third word is the fresh random word.
		function word_t advance_rng();
			word_t t;
			t = rng_first;
			t = t ^ (t << 16);
			t = t ^ (t >> 5);
			t = t ^ (t << 1);
			rng_first = rng_second;
			rng_second = rng_third;
			rng_third = t ^ rng_first ^ rng_second;
			return rng_third;
		endfunction

		function word_t boolean_to_arith(word_t xb, word_t m, word_t g);
			word_t t;
			word_t u;
			word_t a;
			t = (xb ^ g) - g;
			t = t ^ xb;
			u = g ^ m;
			a = (xb ^ u) - u;
			return a ^ t;
		endfunction

		function word_t arith_to_boolean(word_t a, word_t m, word_t g);
			word_t t;
			word_t xb;
			word_t om;
			word_t s;
			t = g << 1;
			xb = g ^ m;
			om = g & xb;
			xb = t ^ a;
			s = (g ^ xb) & m;
			om = om ^ s;
			om = om ^ (t & a);
			// masked carry recurrence, one round per bit above the lowest
			for (int k = 1; k < 32; k++) begin
				s = (t & m) ^ om;
				t = t & a;
				s = s ^ t;
				t = s << 1;
			end
			return xb ^ t;
		endfunction

		function void note_share(logic k, word_t v, word_t m);
			word_t g;
			g = advance_rng();
			if (k == bamc_pkg::KIND_B2A) begin
				b2a_beats++;
				pending_converted.push_back(boolean_to_arith(v, m, g));
			end else begin
				a2b_beats++;
				pending_converted.push_back(arith_to_boolean(v, m, g));
			end
		endfunction

		function void check_converted(word_t actual);
			word_t want;
			if (pending_converted.size() == 0) begin
				$error("converted: expected none, actual %h", actual);
				failures++;
				return;
			end
			want = pending_converted.pop_front();
			checked++;
			if (actual !== want) begin
				$error("converted: expected %h, actual %h", want, actual);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	word_t masked_value;
	word_t mask;
	logic out_valid;
	logic out_ready;
	word_t converted;

	conversion_scoreboard sb;
	int send_idle;
	int recv_idle;
	bit hold_request;
	int cycle_count = 0;

	word_t corner_value [10] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
		32'hAAAA_AAAA};
	word_t corner_mask [10] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hAAAA_AAAA,
		32'hAAAA_AAAA};

	boolean_arithmetic_mask_conversion uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.masked_value(masked_value),
		.mask(mask),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.converted(converted)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Sample both channels as they stood at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_share(kind, masked_value, mask);
			if (out_valid && out_ready)
				sb.check_converted(converted);
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
			@(posedge clk);
		end
	end

	function automatic word_t pick_word();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h7FFF_FFFF;
					default: return word_t'(1) << $urandom_range(31);
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Offer one beat and hold it until the block takes it.
	task automatic send_share(input logic k, input word_t v, input word_t m);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		masked_value <= v;
		mask <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and let a clock edge pass so the last beat is noted before polling.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_converted.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = bamc_pkg::KIND_B2A;
		masked_value = '0;
		mask = '0;
		out_ready = 1'b0;
		send_idle = 29;
		recv_idle = 80;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 10; i++) begin
			send_share(bamc_pkg::KIND_B2A, corner_value[i], corner_mask[i]);
			send_share(bamc_pkg::KIND_A2B, corner_value[i], corner_mask[i]);
		end
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 29;
					recv_idle = 80;
				end
				1: begin
					send_idle = 80;
					recv_idle = 29;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					// Stall the output side while beats keep coming, so the input backs up.
					hold_request = 1'b1;
					for (int n = 0; n < PRESSURE_BEATS; n++)
						send_share(1'($urandom_range(1)), pick_word(), pick_word());
					wait_drained();
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_share(1'($urandom_range(1)), pick_word(), pick_word());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d B2A and %0d A2B shares, %0d checked,",
			sb.b2a_beats, sb.a2b_beats, sb.checked);
		$display("over corner words, skewed and idle-free handshakes and a long output stall.");
		if (sb.failures == 0 && sb.pending_converted.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/bamc_pkg.sv
design/bamc_fifo.sv
design/bamc_front.sv
design/bamc_back.sv
design/boolean_arithmetic_mask_conversion.sv
verif/boolean_arithmetic_mask_conversion_test.sv
